@@ src/rtsc_pkg.sv @@
// Shared constants for the touch sample conditioner.
`timescale 1ns / 1ps
package rtsc_pkg;

    // Sample and register widths
    localparam int RAW_W  = 12;
    localparam int PRS_W  = 13;
    localparam int ORI_W  = 3;
    localparam int REM_W  = 2 * RAW_W;
    localparam int PROD_W = 2 * RAW_W;

    // Screen geometry and output field widths
    localparam int SCREEN_WIDTH  = 320;
    localparam int SCREEN_HEIGHT = 240;
    localparam int POS_X_W       = 9;
    localparam int POS_Y_W       = 8;

    localparam logic [RAW_W-1:0] FULL_SCALE = 12'd4095;
    localparam logic [RAW_W-1:0] X_SCALE    = RAW_W'(SCREEN_WIDTH - 1);
    localparam logic [RAW_W-1:0] Y_SCALE    = RAW_W'(SCREEN_HEIGHT - 1);

    // Pipeline shape: median, clamp, one stage per quotient bit, scale, output
    localparam int DIV_STEPS = RAW_W;
    localparam int NSTG      = DIV_STEPS + 4;
    localparam int ST_MUL    = DIV_STEPS + 2;
    localparam int ST_OUT    = DIV_STEPS + 3;

    // Register map (word index)
    localparam int PADDR_W = 5;
    typedef logic [PADDR_W-3:0] t_reg_idx;
    localparam t_reg_idx REG_FLOOR  = 3'd0;
    localparam t_reg_idx REG_X_LOW  = 3'd1;
    localparam t_reg_idx REG_X_HIGH = 3'd2;
    localparam t_reg_idx REG_Y_LOW  = 3'd3;
    localparam t_reg_idx REG_Y_HIGH = 3'd4;
    localparam t_reg_idx REG_ORIENT = 3'd5;

    // Orientation bits
    localparam int ORI_SWAP  = 0;
    localparam int ORI_INV_X = 1;
    localparam int ORI_INV_Y = 2;

endpackage

@@ src/rtsc_if.sv @@
// Stream channels for measurement sets and conditioned results.
`timescale 1ns / 1ps
interface rtsc_in_if import rtsc_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             pen_up;
    logic [RAW_W-1:0] pressure_one;
    logic [RAW_W-1:0] pressure_two;
    logic [RAW_W-1:0] x_sample_a;
    logic [RAW_W-1:0] x_sample_b;
    logic [RAW_W-1:0] x_sample_c;
    logic [RAW_W-1:0] y_sample_a;
    logic [RAW_W-1:0] y_sample_b;
    logic [RAW_W-1:0] y_sample_c;

    modport source (
        output valid, pen_up, pressure_one, pressure_two,
               x_sample_a, x_sample_b, x_sample_c,
               y_sample_a, y_sample_b, y_sample_c,
        input  ready
    );
    modport sink (
        input  valid, pen_up, pressure_one, pressure_two,
               x_sample_a, x_sample_b, x_sample_c,
               y_sample_a, y_sample_b, y_sample_c,
        output ready
    );
endinterface

interface rtsc_out_if import rtsc_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [POS_X_W-1:0] pos_x;
    logic [POS_Y_W-1:0] pos_y;
    logic               touched;

    modport source (output valid, pos_x, pos_y, touched, input ready);
    modport sink   (input valid, pos_x, pos_y, touched, output ready);
endinterface

@@ src/resistive_touch_sample_conditioner_top.sv @@
// Touch sample conditioner: pressure gate, median, calibration divide, pixel scale.
//
//   channel   dir   handshake               payload
//   i_smp     in    valid/ready             pen_up, pressure_one/two, x/y_sample_a..c
//   o_res     out   valid/ready             pos_x, pos_y, touched
//   apb       in    psel/penable/pready     paddr, pwrite, pwdata, prdata
//
// One measurement set enters per cycle while the output is not stalled; the 12-stage
// restoring divider (one quotient bit per stage) lies between median and pixel scaling.
// Reset (i_rst_n low at a clock edge) empties the pipeline and loads register defaults.
// Each stage holds when the one after it is full and blocked, so a stalled output
// backs up stage by stage and empty slots are filled while the output waits.
`timescale 1ns / 1ps
module resistive_touch_sample_conditioner_top import rtsc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    rtsc_in_if.sink            i_smp,
    rtsc_out_if.source         o_res,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    // Per-axis divider lane payload
    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [RAW_W-1:0] dvs;
        logic [RAW_W-1:0] quo;
        logic             fix;
        logic             fix_hi;
    } t_lane;

    function automatic logic [RAW_W-1:0] mid3(input logic [RAW_W-1:0] a,
                                              input logic [RAW_W-1:0] b,
                                              input logic [RAW_W-1:0] c);
        logic [RAW_W-1:0] lo;
        logic [RAW_W-1:0] hi;
        logic [RAW_W-1:0] m;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        m  = (hi < c) ? hi : c;
        return (lo > m) ? lo : m;
    endfunction

    // Window test and dividend setup: (v - lo) * 4095 as a shift and subtract
    function automatic t_lane clamp_lane(input logic [RAW_W-1:0] v,
                                         input logic [RAW_W-1:0] lo,
                                         input logic [RAW_W-1:0] hi);
        t_lane            n;
        logic [RAW_W-1:0] d;
        d        = v - lo;
        n.rem    = (REM_W'(d) << RAW_W) - REM_W'(d);
        n.dvs    = hi - lo;
        n.quo    = '0;
        n.fix    = (v <= lo) || (v >= hi);
        n.fix_hi = (v > lo);
        return n;
    endfunction

    // One restoring step: produces quotient bit sh
    function automatic t_lane div_step(input t_lane p, input logic [3:0] sh);
        t_lane            n;
        logic [REM_W-1:0] trial;
        n     = p;
        trial = REM_W'(p.dvs) << sh;
        if (p.rem >= trial) begin
            n.rem     = p.rem - trial;
            n.quo[sh] = 1'b1;
        end
        return n;
    endfunction

    function automatic logic [RAW_W-1:0] unit_val(input t_lane l);
        if (l.fix) begin
            return l.fix_hi ? FULL_SCALE : '0;
        end
        return l.quo;
    endfunction

    // Divide by 4095: p = q*4095 + (q + low bits), one correction step
    function automatic logic [RAW_W-1:0] div_full(input logic [PROD_W-1:0] p);
        logic [RAW_W-1:0] q;
        logic [RAW_W:0]   r;
        q = p[PROD_W-1:RAW_W];
        r = {1'b0, p[RAW_W-1:0]} + {1'b0, q};
        return q + RAW_W'(r >= {1'b0, FULL_SCALE});
    endfunction

    // Configuration registers
    logic [PRS_W-1:0] r_floor;
    logic [RAW_W-1:0] r_xlo;
    logic [RAW_W-1:0] r_xhi;
    logic [RAW_W-1:0] r_ylo;
    logic [RAW_W-1:0] r_yhi;
    logic [ORI_W-1:0] r_orient;
    t_reg_idx         w_idx;

    assign w_idx  = paddr[PADDR_W-1:2];
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_floor  <= '0;
            r_xlo    <= '0;
            r_xhi    <= FULL_SCALE;
            r_ylo    <= '0;
            r_yhi    <= FULL_SCALE;
            r_orient <= '0;
        end else if (psel && penable && pwrite) begin
            case (w_idx)
                REG_FLOOR:  r_floor  <= pwdata[PRS_W-1:0];
                REG_X_LOW:  r_xlo    <= pwdata[RAW_W-1:0];
                REG_X_HIGH: r_xhi    <= pwdata[RAW_W-1:0];
                REG_Y_LOW:  r_ylo    <= pwdata[RAW_W-1:0];
                REG_Y_HIGH: r_yhi    <= pwdata[RAW_W-1:0];
                REG_ORIENT: r_orient <= pwdata[ORI_W-1:0];
                default: ;
            endcase
        end
    end

    // Register readback
    always_comb begin
        case (w_idx)
            REG_FLOOR:  prdata = 32'(r_floor);
            REG_X_LOW:  prdata = 32'(r_xlo);
            REG_X_HIGH: prdata = 32'(r_xhi);
            REG_Y_LOW:  prdata = 32'(r_ylo);
            REG_Y_HIGH: prdata = 32'(r_yhi);
            REG_ORIENT: prdata = 32'(r_orient);
            default:    prdata = '0;
        endcase
    end

    // Stage advance chain: a stage loads when it is empty or its successor loads
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] w_en;
    logic [NSTG-1:0] w_vin;

    assign w_en[NSTG-1] = !r_vld[NSTG-1] || o_res.ready;
    assign w_vin[0]     = i_smp.valid;

    for (genvar k = 0; k < NSTG - 1; k++) begin : g_en
        assign w_en[k]    = !r_vld[k] || w_en[k+1];
        assign w_vin[k+1] = r_vld[k];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NSTG; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= w_vin[k];
                end
            end
        end
    end

    assign i_smp.ready = w_en[0];

    // Stage 0: pressure gate and medians
    logic             r_tch0;
    logic [RAW_W-1:0] r_mx;
    logic [RAW_W-1:0] r_my;
    logic [PRS_W-1:0] w_prs;

    assign w_prs = {1'b0, i_smp.pressure_one} + ({1'b0, FULL_SCALE} - {1'b0, i_smp.pressure_two});

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_tch0 <= !i_smp.pen_up && (w_prs >= r_floor);
            r_mx   <= mid3(i_smp.x_sample_a, i_smp.x_sample_b, i_smp.x_sample_c);
            r_my   <= mid3(i_smp.y_sample_a, i_smp.y_sample_b, i_smp.y_sample_c);
        end
    end

    // Stage 1: clamp window; stages 2..13: divider lanes
    t_lane r_lx  [0:DIV_STEPS];
    t_lane r_ly  [0:DIV_STEPS];
    logic  r_tchl[0:DIV_STEPS];

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_lx[0]   <= clamp_lane(r_mx, r_xlo, r_xhi);
            r_ly[0]   <= clamp_lane(r_my, r_ylo, r_yhi);
            r_tchl[0] <= r_tch0;
        end
    end

    for (genvar j = 1; j <= DIV_STEPS; j++) begin : g_div
        t_lane n_lx;
        t_lane n_ly;

        always_comb begin
            n_lx = div_step(r_lx[j-1], 4'(DIV_STEPS - j));
            n_ly = div_step(r_ly[j-1], 4'(DIV_STEPS - j));
        end

        always_ff @(posedge i_clk) begin
            if (w_en[j+1]) begin
                r_lx[j]   <= n_lx;
                r_ly[j]   <= n_ly;
                r_tchl[j] <= r_tchl[j-1];
            end
        end
    end

    // Orientation and pixel multiply
    logic [RAW_W-1:0]  n_ua;
    logic [RAW_W-1:0]  n_ub;
    logic [PROD_W-1:0] r_px;
    logic [PROD_W-1:0] r_py;
    logic              r_tchm;

    always_comb begin
        n_ua = unit_val(r_lx[DIV_STEPS]);
        n_ub = unit_val(r_ly[DIV_STEPS]);
        if (r_orient[ORI_SWAP]) begin
            n_ua = unit_val(r_ly[DIV_STEPS]);
            n_ub = unit_val(r_lx[DIV_STEPS]);
        end
        if (r_orient[ORI_INV_X]) begin
            n_ua = FULL_SCALE - n_ua;
        end
        if (r_orient[ORI_INV_Y]) begin
            n_ub = FULL_SCALE - n_ub;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[ST_MUL]) begin
            r_px   <= PROD_W'(n_ua) * PROD_W'(X_SCALE);
            r_py   <= PROD_W'(n_ub) * PROD_W'(Y_SCALE);
            r_tchm <= r_tchl[DIV_STEPS];
        end
    end

    // Output register: divide by full scale, zero when rejected
    logic [RAW_W-1:0]   n_qx;
    logic [RAW_W-1:0]   n_qy;
    logic [POS_X_W-1:0] r_pos_x;
    logic [POS_Y_W-1:0] r_pos_y;
    logic               r_touched;

    assign n_qx = div_full(r_px);
    assign n_qy = div_full(r_py);

    always_ff @(posedge i_clk) begin
        if (w_en[ST_OUT]) begin
            r_pos_x   <= r_tchm ? n_qx[POS_X_W-1:0] : '0;
            r_pos_y   <= r_tchm ? n_qy[POS_Y_W-1:0] : '0;
            r_touched <= r_tchm;
        end
    end

    assign o_res.valid   = r_vld[ST_OUT];
    assign o_res.pos_x   = r_pos_x;
    assign o_res.pos_y   = r_pos_y;
    assign o_res.touched = r_touched;

    // Checks
    a_full_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_smp.ready |-> (&r_vld))
        else $error("input blocked while pipeline has an empty stage");

    a_quo_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[DIV_STEPS+1] && !r_lx[DIV_STEPS].fix) |-> (r_lx[DIV_STEPS].quo < FULL_SCALE))
        else $error("x quotient out of window range");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[ST_MUL] && w_en[ST_OUT] && !r_tchm) |=>
        (r_pos_x == '0 && r_pos_y == '0 && !r_touched))
        else $error("rejected touch carried nonzero position");

endmodule
